@@ hdl/rc4_pkg.sv @@
`default_nettype none
package rc4_pkg;
   localparam int BYTE_W = 8;
   localparam int PERM_DEPTH = 256;
   localparam int KEY_MAX_DEFAULT = 256;

   // request kinds carried on req_tuser
   localparam logic CMD_KEY = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic en;
      byte_type addr;
      byte_type data;
   } perm_wr_type;
endpackage
`default_nettype wire

@@ hdl/rc4_ram.sv @@
`default_nettype none
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ hdl/rc4_keystream_cipher_unit.sv @@
`default_nettype none
// RC4 keystream unit. Requests with req_tuser low are key bytes: they give no
// response, bytes beyond KEY_MAX are dropped, and the one with req_tlast high
// starts the key schedule. The schedule refills the state table with the
// identity and then runs its 256 swap steps (read S[n], read S[j], write S[n],
// write S[j]) before the next request is taken. Requests with req_tuser high
// are data bytes: each is held while the response register is still occupied,
// and its response is set by the accesses it makes to the state table one
// after another (read S[i] at acceptance, read S[j], write S[i], write S[j]),
// with S[t] read beside the first write and forwarded. After reset the state
// table is filled with the identity while req_tready stays low. One response
// register lets a new request be accepted while the previous response waits.
module rc4_keystream_cipher_unit #(
   parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tuser,   // [0] cmd
   input  wire logic        req_tlast,   // key_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [7:0] keystream_byte, [15:8] cipher_byte
);
   import rc4_pkg::*;

   localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int CNT_W = $clog2(KEY_MAX + 1);
   localparam logic [CNT_W-1:0] KEY_FULL = CNT_W'(KEY_MAX);
   localparam byte_type LAST_IDX = byte_type'(PERM_DEPTH - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FILL  = 4'd1;
   localparam logic [3:0] ST_KFILL = 4'd2;
   localparam logic [3:0] ST_K0    = 4'd3;
   localparam logic [3:0] ST_K1    = 4'd4;
   localparam logic [3:0] ST_K2    = 4'd5;
   localparam logic [3:0] ST_K3    = 4'd6;
   localparam logic [3:0] ST_D1    = 4'd7;
   localparam logic [3:0] ST_D2    = 4'd8;
   localparam logic [3:0] ST_D3    = 4'd9;
   localparam logic [3:0] ST_D4    = 4'd10;

   logic [3:0] state_ff, state_in;
   byte_type i_ff, i_in;
   byte_type j_ff, j_in;
   byte_type n_ff, n_in;
   byte_type a_ff, a_in;
   byte_type b_ff, b_in;
   byte_type t_ff, t_in;
   byte_type d_ff, d_in;
   byte_type ks_ff, ks_in;
   logic [KIDX_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] key_count_ff, key_count_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   perm_wr_type perm_wr;
   byte_type perm_rd_addr;
   byte_type perm_rd_data;
   logic key_we;
   logic [KIDX_W-1:0] key_rd_addr;
   byte_type key_rd_data;

   logic req_fire;
   logic out_free;
   byte_type add_b;
   byte_type sum;
   byte_type ks_now;
   logic [CNT_W-1:0] k_next;
   logic [CNT_W-1:0] count_next;

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
      .clock   (clock),
      .wr_en   (perm_wr.en),
      .wr_addr (perm_wr.addr),
      .wr_data (perm_wr.data),
      .rd_addr (perm_rd_addr),
      .rd_data (perm_rd_data)
   );

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_MAX), .ADDR_W(KIDX_W)) u_key (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_count_ff[KIDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign key_we = req_fire && (req_tuser == CMD_KEY) && (key_count_ff < KEY_FULL);
   assign key_rd_addr = k_ff;

   // shared index adder: j + S[x] (+ key byte during the schedule), or S[i] + S[j] for the output index
   assign add_b = (state_ff == ST_K1) ? key_rd_data : '0;
   assign sum = (state_ff == ST_D2) ? byte_type'(a_ff + perm_rd_data)
                                    : byte_type'(j_ff + perm_rd_data + add_b);

   // S[t] read beside the S[i] write, patched for the swap
   always_comb begin
      priority if (t_ff == j_ff) begin
         ks_now = a_ff;
      end else if (t_ff == i_ff) begin
         ks_now = b_ff;
      end else begin
         ks_now = perm_rd_data;
      end
   end

   assign k_next = CNT_W'(k_ff) + CNT_W'(1);
   assign count_next = key_count_ff + CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      n_in = n_ff;
      a_in = a_ff;
      b_in = b_ff;
      t_in = t_ff;
      d_in = d_ff;
      ks_in = ks_ff;
      k_in = k_ff;
      key_count_in = key_count_ff;
      len_in = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      perm_wr = '0;
      perm_rd_addr = i_ff;

      unique case (state_ff)
         ST_IDLE: begin
            perm_rd_addr = byte_type'(i_ff + 1'b1);
            if (req_fire) begin
               if (req_tuser == CMD_DATA) begin
                  i_in = byte_type'(i_ff + 1'b1);
                  d_in = req_tdata;
                  state_in = ST_D1;
               end else begin
                  if (key_count_ff < KEY_FULL) begin
                     key_count_in = count_next;
                  end
                  if (req_tlast) begin
                     len_in = (key_count_ff < KEY_FULL) ? count_next : key_count_ff;
                     key_count_in = '0;
                     j_in = '0;
                     k_in = '0;
                     n_in = '0;
                     state_in = ST_KFILL;
                  end
               end
            end
         end
         ST_FILL, ST_KFILL: begin
            perm_wr.en = 1'b1;
            perm_wr.addr = n_ff;
            perm_wr.data = n_ff;
            n_in = byte_type'(n_ff + 1'b1);
            if (n_ff == LAST_IDX) begin
               state_in = (state_ff == ST_FILL) ? ST_IDLE : ST_K0;
            end
         end
         ST_K0: begin
            perm_rd_addr = n_ff;
            state_in = ST_K1;
         end
         ST_K1: begin
            a_in = perm_rd_data;
            j_in = sum;
            perm_rd_addr = sum;
            state_in = ST_K2;
         end
         ST_K2: begin
            perm_wr.en = 1'b1;
            perm_wr.addr = n_ff;
            perm_wr.data = perm_rd_data;
            state_in = ST_K3;
         end
         ST_K3: begin
            perm_wr.en = 1'b1;
            perm_wr.addr = j_ff;
            perm_wr.data = a_ff;
            n_in = byte_type'(n_ff + 1'b1);
            k_in = (k_next >= len_ff) ? '0 : k_next[KIDX_W-1:0];
            if (n_ff == LAST_IDX) begin
               i_in = '0;
               j_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_K0;
            end
         end
         ST_D1: begin
            a_in = perm_rd_data;
            j_in = sum;
            perm_rd_addr = sum;
            state_in = ST_D2;
         end
         ST_D2: begin
            b_in = perm_rd_data;
            perm_wr.en = 1'b1;
            perm_wr.addr = i_ff;
            perm_wr.data = perm_rd_data;
            t_in = sum;
            perm_rd_addr = sum;
            state_in = ST_D3;
         end
         ST_D3: begin
            perm_wr.en = 1'b1;
            perm_wr.addr = j_ff;
            perm_wr.data = a_ff;
            ks_in = ks_now;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {ks_now ^ d_ff, ks_now};
               state_in = ST_IDLE;
            end else begin
               state_in = ST_D4;
            end
         end
         ST_D4: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {ks_ff ^ d_ff, ks_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         i_ff <= '0;
         j_ff <= '0;
         n_ff <= '0;
         k_ff <= '0;
         key_count_ff <= '0;
         len_ff <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
         n_ff <= n_in;
         k_ff <= k_in;
         key_count_ff <= key_count_in;
         len_ff <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      t_ff <= t_in;
      d_ff <= d_in;
      ks_ff <= ks_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef ASSERT_OFF
   a_data_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == CMD_DATA) |=> state_ff == ST_D1)
      else $error("data request did not start the generator");

   a_key_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == CMD_KEY) && req_tlast
      |=> (state_ff == ST_KFILL) && (key_count_ff == '0) && (len_ff != '0))
      else $error("last key byte did not start the schedule");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KEY_FULL)
      else $error("key count beyond capacity");

   a_sched_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K3) && (n_ff == LAST_IDX)
      |=> (state_ff == ST_IDLE) && (i_ff == '0) && (j_ff == '0))
      else $error("stream indices not cleared after schedule");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending response lost");
`endif
endmodule
`default_nettype wire

@@ verif/rc4_keystream_cipher_unit_tb.sv @@
`default_nettype none
module rc4_keystream_cipher_unit_tb;
   import rc4_pkg::*;

   localparam int CLK_HALF = 10;
   localparam int RESET_CYCLES = 11;
   localparam int TARGET_REQUESTS = 1150;
   // leaves room for every key schedule many times over
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 1400;

   typedef struct packed {
      byte_type cipher;
      byte_type keystream;
   } cipher_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] byte_in
   logic        req_tuser = CMD_KEY;   // [0] cmd
   logic        req_tlast = 1'b0;   // key_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // [7:0] keystream_byte, [15:8] cipher_byte

   // predicted cipher state
   byte_type sbox [PERM_DEPTH];
   byte_type key_bytes [PERM_DEPTH];
   int       key_len;
   byte_type idx_i;
   byte_type idx_j;

   cipher_result_type expected_results[$];

   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int schedules_run = 0;
   int cycle_count = 0;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;

   rc4_keystream_cipher_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  expected_results.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic void init_state();
      for (int n = 0; n < PERM_DEPTH; n++) begin
         sbox[n] = byte_type'(n);
         key_bytes[n] = '0;
      end
      key_len = 0;
      idx_i = '0;
      idx_j = '0;
   endfunction

   function automatic void schedule_key();
      int       len;
      int       k;
      byte_type j;
      byte_type tmp;
      len = (key_len == 0) ? 1 : key_len;
      for (int n = 0; n < PERM_DEPTH; n++) begin
         sbox[n] = byte_type'(n);
      end
      j = '0;
      k = 0;
      for (int n = 0; n < PERM_DEPTH; n++) begin
         j = j + sbox[n] + key_bytes[k];
         tmp = sbox[n];
         sbox[n] = sbox[j];
         sbox[j] = tmp;
         k++;
         if (k >= len) begin
            k = 0;
         end
      end
      idx_i = '0;
      idx_j = '0;
      key_len = 0;
      schedules_run++;
   endfunction

   function automatic void apply_request(logic cmd, byte_type value, logic last_key);
      byte_type          tmp;
      byte_type          t;
      cipher_result_type res;
      if (cmd == CMD_KEY) begin
         // bytes past the key store capacity are dropped
         if (key_len < KEY_MAX_DEFAULT) begin
            key_bytes[key_len] = value;
            key_len++;
         end
         if (last_key) begin
            schedule_key();
         end
      end else begin
         idx_i = idx_i + 8'd1;
         idx_j = idx_j + sbox[idx_i];
         tmp = sbox[idx_i];
         sbox[idx_i] = sbox[idx_j];
         sbox[idx_j] = tmp;
         t = sbox[idx_i] + sbox[idx_j];
         res.keystream = sbox[t];
         res.cipher = sbox[t] ^ value;
         expected_results.push_back(res);
      end
   endfunction

   task automatic send_request(input logic cmd, input byte_type value, input logic last_key);
      int gap;
      gap = send_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= value;
      req_tlast <= last_key;
      do @(posedge clock); while (!req_tready);
      apply_request(cmd, value, last_key);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic send_key(input int len);
      for (int n = 0; n < len; n++) begin
         send_request(CMD_KEY, byte_type'($urandom), n == len - 1);
      end
   endtask

   task automatic send_data(input int len);
      for (int n = 0; n < len; n++) begin
         send_request(CMD_DATA, byte_type'($urandom), $urandom_range(0, 7) == 0);
      end
   endtask

   // response side: random stall per response, then compare with the oldest prediction
   initial begin
      int                stall;
      cipher_result_type want;
      forever begin
         stall = recv_idle ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %04h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[7:0] !== want.keystream) begin
               $display("%0t: keystream_byte mismatch, expected %02h, got %02h",
                        $time, want.keystream, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[15:8] !== want.cipher) begin
               $display("%0t: cipher_byte mismatch, expected %02h, got %02h",
                        $time, want.cipher, rsp_tdata[15:8]);
               error_count++;
            end
            responses_checked++;
         end
      end
   end

   task automatic test_data_before_key();
      // runs on the identity table left by reset; the flag is ignored on data
      send_request(CMD_DATA, 8'h00, 1'b0);
      send_request(CMD_DATA, 8'hff, 1'b0);
      send_request(CMD_DATA, 8'ha5, 1'b1);
      send_request(CMD_DATA, 8'h5a, 1'b0);
   endtask

   task automatic test_short_keys();
      send_request(CMD_KEY, 8'h4b, 1'b0);
      send_request(CMD_KEY, 8'h65, 1'b0);
      send_request(CMD_KEY, 8'h79, 1'b1);
      send_request(CMD_DATA, 8'h00, 1'b0);
      send_request(CMD_DATA, 8'hff, 1'b0);
      // single byte keys at both extremes
      send_request(CMD_KEY, 8'h00, 1'b1);
      send_request(CMD_DATA, 8'h01, 1'b0);
      send_request(CMD_DATA, 8'h80, 1'b0);
      send_request(CMD_KEY, 8'hff, 1'b1);
      send_request(CMD_DATA, 8'h7f, 1'b0);
   endtask

   task automatic test_partial_key();
      // data arriving while a key is half loaded uses the current table
      send_request(CMD_KEY, 8'h13, 1'b0);
      send_request(CMD_KEY, 8'hec, 1'b0);
      send_request(CMD_DATA, 8'h3c, 1'b0);
      send_request(CMD_DATA, 8'hc3, 1'b1);
      wait_drained();
      send_request(CMD_KEY, 8'h96, 1'b1);
      send_request(CMD_DATA, 8'h00, 1'b0);
      send_request(CMD_DATA, 8'hff, 1'b0);
   endtask

   task automatic test_long_keys();
      // exactly a full key store, then one that overflows with the flag on a dropped byte
      send_key(KEY_MAX_DEFAULT);
      send_data(3);
      send_key(KEY_MAX_DEFAULT + 4);
      send_data(3);
   endtask

   task automatic test_random_traffic();
      int kind;
      while (requests_sent < TARGET_REQUESTS) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            send_key(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                 : $urandom_range(1, 16));
            send_data($urandom_range(1, 24));
         end else if (kind <= 7) begin
            send_data($urandom_range(1, 24));
         end else if (kind == 8) begin
            // key left pending while data goes through
            for (int n = $urandom_range(1, 8); n > 0; n--) begin
               send_request(CMD_KEY, byte_type'($urandom), 1'b0);
            end
            send_data($urandom_range(1, 8));
         end else begin
            for (int n = $urandom_range(1, 8); n > 0; n--) begin
               send_request(logic'($urandom_range(0, 1)), byte_type'($urandom),
                            logic'($urandom_range(0, 3) == 0));
            end
         end
      end
   endtask

   initial begin
      init_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_data_before_key();
      test_short_keys();
      test_partial_key();
      test_long_keys();
      test_random_traffic();
      wait_drained();
      send_idle = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d requests with %0d key schedules; %0d responses compared",
               requests_sent, schedules_run, responses_checked);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ rc4_keystream_cipher_unit.f @@
hdl/rc4_pkg.sv
hdl/rc4_ram.sv
hdl/rc4_keystream_cipher_unit.sv
verif/rc4_keystream_cipher_unit_tb.sv
